// File: sv/pclq_pkg.sv
// ----------------------------------------------------------------------------
// pclq_pkg: shared types and constants for the proximity contact log queue
// Field widths, log geometry, outcome codes and controller/datapath links.
// ----------------------------------------------------------------------------
package pclq_pkg;

	// log geometry
	localparam int LOG_DEPTH = 4096;
	localparam int PTR_W     = $clog2(LOG_DEPTH);
	localparam int CNT_W     = 13;

	// field widths
	localparam int ADDR_W = 48;
	localparam int STR_W  = 8;
	localparam int TIME_W = 32;
	localparam int OUTC_W = 3;

	// one stored record: address, strength, time stamp
	localparam int LOG_W = ADDR_W + STR_W + TIME_W;

	// reset value of the near threshold (-86 dBm)
	localparam logic signed [STR_W-1:0] THR_RESET = -8'sd86;

	// request kinds
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_ACK  = 1'b1;

	// result outcome codes
	typedef enum logic [OUTC_W-1:0] {
		OUTC_FAR     = 3'd0,
		OUTC_LIVE    = 3'd1,
		OUTC_LOGGED  = 3'd2,
		OUTC_DROPPED = 3'd3,
		OUTC_POPPED  = 3'd4,
		OUTC_EMPTY   = 3'd5
	} outcome_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept_en;  // input channel may take a transaction
		logic rd_en;      // read the head record
		logic commit;     // load the result and update the log state
	} pclq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_fire;    // input transaction this cycle
		logic pop_hit;    // held item pops a stored record
		logic out_free;   // result register can be loaded
	} pclq_sts_t;

endpackage

// File: sv/pclq_in_if.sv
// ----------------------------------------------------------------------------
// pclq_in_if: request channel
// Scan reports and acknowledges with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pclq_in_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic [pclq_pkg::ADDR_W-1:0]         device_address;
	logic signed [pclq_pkg::STR_W-1:0]   signal_strength;
	logic [pclq_pkg::TIME_W-1:0]         now_ms;
	logic                                link_connected;

	modport source (
		output valid, req_type, device_address, signal_strength, now_ms,
		       link_connected,
		input  ready
	);
	modport sink (
		input  valid, req_type, device_address, signal_strength, now_ms,
		       link_connected,
		output ready
	);
endinterface

// File: sv/pclq_out_if.sv
// ----------------------------------------------------------------------------
// pclq_out_if: result channel
// One result per request, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pclq_out_if;
	logic                                valid;
	logic                                ready;
	logic [pclq_pkg::OUTC_W-1:0]         outcome;
	logic [pclq_pkg::ADDR_W-1:0]         out_address;
	logic signed [pclq_pkg::STR_W-1:0]   out_strength;
	logic [pclq_pkg::TIME_W-1:0]         age_ms;
	logic [pclq_pkg::CNT_W-1:0]          log_count;

	modport source (
		output valid, outcome, out_address, out_strength, age_ms, log_count,
		input  ready
	);
	modport sink (
		input  valid, outcome, out_address, out_strength, age_ms, log_count,
		output ready
	);
endinterface

// File: sv/pclq_cfg_if.sv
// ----------------------------------------------------------------------------
// pclq_cfg_if: configuration write channel
// Carries the near threshold with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pclq_cfg_if;
	logic                                valid;
	logic                                ready;
	logic signed [pclq_pkg::STR_W-1:0]   near_threshold;

	modport source (
		output valid, near_threshold,
		input  ready
	);
	modport sink (
		input  valid, near_threshold,
		output ready
	);
endinterface

// File: sv/pclq_ram.sv
// ----------------------------------------------------------------------------
// pclq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pclq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/pclq_ctrl.sv
// ----------------------------------------------------------------------------
// pclq_ctrl: sequencing controller
// Takes one request, issues the head read for a pop, then commits the result.
// ----------------------------------------------------------------------------
module pclq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  pclq_pkg::pclq_sts_t sts,
	output pclq_pkg::pclq_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sts.in_fire) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (sts.pop_hit) state_q <= ST_POP;
					else if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_POP: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.accept_en = 1'b1;
			ST_EXEC: begin
				cmd.rd_en  = sts.pop_hit;
				cmd.commit = !sts.pop_hit && sts.out_free;
			end
			ST_POP:  cmd.commit = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: sv/pclq_dp.sv
// ----------------------------------------------------------------------------
// pclq_dp: queue datapath
// Request hold register, threshold, log pointers, record RAM and result register.
// ----------------------------------------------------------------------------
module pclq_dp (
	input  logic                clk,
	input  logic                arst_n,
	pclq_in_if.sink             req,
	pclq_out_if.source          rsp,
	pclq_cfg_if.sink            cfg,
	input  pclq_pkg::pclq_cmd_t cmd,
	output pclq_pkg::pclq_sts_t sts
);

	localparam logic [pclq_pkg::CNT_W-1:0] FULL_CNT = pclq_pkg::CNT_W'(pclq_pkg::LOG_DEPTH);
	localparam logic [pclq_pkg::PTR_W-1:0] LAST_PTR =
		pclq_pkg::PTR_W'(pclq_pkg::LOG_DEPTH - 1);

	// threshold register
	logic signed [pclq_pkg::STR_W-1:0] thr_q;

	// held request
	logic                              req_type_q;
	logic [pclq_pkg::ADDR_W-1:0]       addr_q;
	logic signed [pclq_pkg::STR_W-1:0] str_q;
	logic [pclq_pkg::TIME_W-1:0]       now_q;
	logic                              link_q;

	// log state
	logic [pclq_pkg::PTR_W-1:0] head_q;
	logic [pclq_pkg::PTR_W-1:0] tail_q;
	logic [pclq_pkg::CNT_W-1:0] occ_q;
	logic [pclq_pkg::CNT_W-1:0] occ_nxt;

	// result register
	logic                              out_valid_q;
	pclq_pkg::outcome_t                outc_q;
	logic [pclq_pkg::ADDR_W-1:0]       out_addr_q;
	logic signed [pclq_pkg::STR_W-1:0] out_str_q;
	logic [pclq_pkg::TIME_W-1:0]       age_q;
	logic [pclq_pkg::CNT_W-1:0]        cnt_q;

	pclq_pkg::outcome_t                outc;
	logic [pclq_pkg::LOG_W-1:0]        rd_rec;
	logic [pclq_pkg::ADDR_W-1:0]       rd_addr_f;
	logic signed [pclq_pkg::STR_W-1:0] rd_str_f;
	logic [pclq_pkg::TIME_W-1:0]       rd_time_f;
	logic                              wr_en;

	// handshakes
	assign req.ready   = cmd.accept_en;
	assign cfg.ready   = 1'b1;
	assign sts.in_fire = req.valid && cmd.accept_en;
	assign sts.out_free = !out_valid_q || rsp.ready;
	assign sts.pop_hit  = (outc == pclq_pkg::OUTC_POPPED);

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pclq_pkg::THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.near_threshold;
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (sts.in_fire) begin
			req_type_q <= req.req_type;
			addr_q     <= req.device_address;
			str_q      <= req.signal_strength;
			now_q      <= req.now_ms;
			link_q     <= req.link_connected;
		end
	end

	// classify the held request
	always_comb begin
		if (req_type_q == pclq_pkg::REQ_ACK) begin
			outc = (occ_q == '0) ? pclq_pkg::OUTC_EMPTY : pclq_pkg::OUTC_POPPED;
		end else if (str_q < thr_q) begin
			outc = pclq_pkg::OUTC_FAR;
		end else if (link_q) begin
			outc = pclq_pkg::OUTC_LIVE;
		end else if (occ_q == FULL_CNT) begin
			outc = pclq_pkg::OUTC_DROPPED;
		end else begin
			outc = pclq_pkg::OUTC_LOGGED;
		end
	end

	// occupancy after this item
	always_comb begin
		case (outc)
			pclq_pkg::OUTC_LOGGED: occ_nxt = occ_q + 1'b1;
			pclq_pkg::OUTC_POPPED: occ_nxt = occ_q - 1'b1;
			default:               occ_nxt = occ_q;
		endcase
	end

	assign wr_en = cmd.commit && (outc == pclq_pkg::OUTC_LOGGED);

	// record store
	pclq_ram #(
		.WIDTH (pclq_pkg::LOG_W),
		.DEPTH (pclq_pkg::LOG_DEPTH)
	) u_log_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data ({addr_q, str_q, now_q}),
		.rd_en   (cmd.rd_en),
		.rd_addr (head_q),
		.rd_data (rd_rec)
	);

	assign {rd_addr_f, rd_str_f, rd_time_f} = rd_rec;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else if (cmd.commit) begin
			occ_q <= occ_nxt;
			if (outc == pclq_pkg::OUTC_LOGGED) begin
				tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
			end
			if (outc == pclq_pkg::OUTC_POPPED) begin
				head_q <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			outc_q <= outc;
			cnt_q  <= occ_nxt;
			case (outc)
				pclq_pkg::OUTC_LIVE: begin
					out_addr_q <= addr_q;
					out_str_q  <= str_q;
					age_q      <= '0;
				end
				pclq_pkg::OUTC_POPPED: begin
					out_addr_q <= rd_addr_f;
					out_str_q  <= rd_str_f;
					age_q      <= now_q - rd_time_f;
				end
				default: begin
					out_addr_q <= '0;
					out_str_q  <= '0;
					age_q      <= '0;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.outcome      = outc_q;
	assign rsp.out_address  = out_addr_q;
	assign rsp.out_strength = out_str_q;
	assign rsp.age_ms       = age_q;
	assign rsp.log_count    = cnt_q;

endmodule

// File: sv/proximity_contact_log_queue.sv
// ----------------------------------------------------------------------------
// proximity_contact_log_queue: contact report filter with a circular log
// Scan reports below the near threshold are answered as far; near reports go
// out live while the link is up, otherwise into a 4096-record log (dropped
// when full). An acknowledge pops the oldest record, age in milliseconds.
//
// Channels: req takes one request per transaction, rsp gives exactly one
// result per request in order, cfg writes the signed near threshold
// (always ready, reset value -86 dBm).
// Timing: a request is captured in the hold register, then its result is
// loaded into the result register once that is free; a pop first passes
// through the registered read of the record RAM.
// The controller holds one request at a time and takes a new one only
// after the result of the last has been committed.
// Reset clears the pointers and the count (log empty) and the result valid
// flag; log contents and the result payload are left as they are.
// While rsp is stalled a result waits in its register; one further request
// is still taken and held until that register is free.
// ----------------------------------------------------------------------------
module proximity_contact_log_queue (
	input  logic       clk,
	input  logic       arst_n,
	pclq_in_if.sink    req,
	pclq_out_if.source rsp,
	pclq_cfg_if.sink   cfg
);

	pclq_pkg::pclq_cmd_t cmd;
	pclq_pkg::pclq_sts_t sts;

	// sequencing
	pclq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// storage and result formation
	pclq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
